// File: src/lbfb_pkg.sv
// ----------------------------------------------------------------------------
// lbfb_pkg
// Shared constants, action codes and controller/datapath handshake structs
// for the low-resolution block framebuffer.
// ----------------------------------------------------------------------------
package lbfb_pkg;

  // Grid size in blocks
  localparam int COLUMNS    = 40;
  localparam int BLOCK_ROWS = 48;

  // Storage geometry
  localparam int COORD_W     = 6;   // holds any in-range column or block row
  localparam int ADDR_W      = 11;  // two 1 KB pages
  localparam int PAGE_ADDR_W = 10;
  localparam int STORE_DEPTH = 2048;

  // Action codes
  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_SET   = 3'd1;
  localparam logic [2:0] ACT_GET   = 3'd2;
  localparam logic [2:0] ACT_HLINE = 3'd3;
  localparam logic [2:0] ACT_VLINE = 3'd4;
  localparam logic [2:0] ACT_RECT  = 3'd5;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;        // latch the incoming transaction
    logic init_wr;     // reset clearing pass write
    logic fill_wr;     // page clear write
    logic sweep_clr;   // restart the sweep counter
    logic sweep_step;  // advance the sweep counter
    logic mem_rd;      // read the byte under the cursor
    logic cell_wr;     // write phase of a cell read-modify-write
    logic advance;     // step the cursor in raster order
    logic res_load;    // move the pending result into the output register
  } lbfb_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic in_clear;    // incoming action is a clear
    logic in_ok;       // incoming action touches memory
    logic sweep_all;   // sweep counter at the last store byte
    logic sweep_page;  // sweep counter at the last byte of a page
    logic cell_last;   // cursor at the last cell of the span
    logic out_free;    // output register can take a result this cycle
  } lbfb_stat_t;

endpackage

// File: src/lbfb_ifs.sv
// ----------------------------------------------------------------------------
// lbfb_req_if / lbfb_rsp_if
// Valid/ready channels for drawing commands and their results.
// ----------------------------------------------------------------------------

// Command channel
interface lbfb_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] x_end;
  logic [7:0] y_end;
  logic [7:0] width;
  logic [7:0] height;
  logic [3:0] color;

  modport source (
    output valid, action, x, y, x_end, y_end, width, height, color,
    input  ready
  );
  modport sink (
    input  valid, action, x, y, x_end, y_end, width, height, color,
    output ready
  );
endinterface

// Result channel
interface lbfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] read_color;
  logic       accepted;

  modport source (
    output valid, read_color, accepted,
    input  ready
  );
  modport sink (
    input  valid, read_color, accepted,
    output ready
  );
endinterface

// File: src/lbfb_ctrl.sv
// ----------------------------------------------------------------------------
// lbfb_ctrl
// Sequencer: reset clearing pass, page clear, per-cell read-modify-write
// and result hand-off.
// ----------------------------------------------------------------------------
module lbfb_ctrl
  import lbfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lbfb_stat_t stat,
  output lbfb_cmd_t  cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.init_wr    = 1'b1;
        cmd.sweep_step = 1'b1;
        if (stat.sweep_all) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          cmd.sweep_clr = 1'b1;
          if (stat.in_clear) begin
            state_next = S_FILL;
          end else if (stat.in_ok) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FILL: begin
        cmd.fill_wr    = 1'b1;
        cmd.sweep_step = 1'b1;
        if (stat.sweep_page) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.cell_wr = 1'b1;
        if (!stat.cell_last) begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end else if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/lbfb_datapath.sv
// ----------------------------------------------------------------------------
// lbfb_datapath
// Command checks and clipping, raster cursor, interleaved address mapping,
// screen store and output register.
// ----------------------------------------------------------------------------
module lbfb_datapath
  import lbfb_pkg::*;
#(
  parameter int COLUMNS    = lbfb_pkg::COLUMNS,
  parameter int BLOCK_ROWS = lbfb_pkg::BLOCK_ROWS
)
(
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // incoming transaction fields
  input  logic [2:0] action,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] x_end,
  input  logic [7:0] y_end,
  input  logic [7:0] width,
  input  logic [7:0] height,
  input  logic [3:0] color,
  // controller link
  input  lbfb_cmd_t  cmd,
  output lbfb_stat_t stat,
  // result channel
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [3:0] read_color,
  output logic       accepted
);

  // Interleaved text-page mapping: r = row/2, offset 128*(r%8) + 40*(r/8) + col
  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic               page_sel,
    input logic [COORD_W-1:0] c,
    input logic [COORD_W-1:0] r6
  );
    logic [4:0]        r;
    logic [ADDR_W-1:0] off;
    r   = r6[5:1];
    off = {1'b0, r[2:0], 7'b0} + {4'b0, r[4:3], 5'b0} + {6'b0, r[4:3], 3'b0}
        + {5'b0, c};
    return {page_sel, {PAGE_ADDR_W{1'b0}}} + off;
  endfunction

  logic                 page;
  logic [2:0]           act_q;
  logic [3:0]           color_q;
  logic [COORD_W-1:0]   col;
  logic [COORD_W-1:0]   row;
  logic [COORD_W-1:0]   x_start;
  logic [COORD_W-1:0]   col_last;
  logic [COORD_W-1:0]   row_last;
  logic [ADDR_W-1:0]    sweep;
  logic [7:0]           rdata;
  logic                 pend_acc;
  logic [3:0]           pend_color;
  logic                 out_valid;
  logic [3:0]           out_color;
  logic                 out_acc;
  logic [7:0]           mem [STORE_DEPTH];

  // Incoming command checks and clipping
  logic               on_grid;
  logic [7:0]         xe_c;
  logic [7:0]         ye_c;
  logic [8:0]         xr;
  logic [8:0]         yb;
  logic [8:0]         xr_c;
  logic [8:0]         yb_c;
  logic [8:0]         xr_m1;
  logic [8:0]         yb_m1;
  logic               ok;
  logic [COORD_W-1:0] col_last_in;
  logic [COORD_W-1:0] row_last_in;

  always_comb begin
    on_grid = (x < 8'(COLUMNS)) && (y < 8'(BLOCK_ROWS));
    xe_c   = (x_end >= 8'(COLUMNS))    ? 8'(COLUMNS - 1)    : x_end;
    ye_c   = (y_end >= 8'(BLOCK_ROWS)) ? 8'(BLOCK_ROWS - 1) : y_end;
    xr     = {1'b0, x} + {1'b0, width};
    yb     = {1'b0, y} + {1'b0, height};
    xr_c   = (xr > 9'(COLUMNS))    ? 9'(COLUMNS)    : xr;
    yb_c   = (yb > 9'(BLOCK_ROWS)) ? 9'(BLOCK_ROWS) : yb;
    xr_m1  = xr_c - 9'd1;
    yb_m1  = yb_c - 9'd1;
    col_last_in = x[COORD_W-1:0];
    row_last_in = y[COORD_W-1:0];
    unique case (action) inside
      ACT_CLEAR: ok = 1'b1;
      ACT_SET, ACT_GET: ok = on_grid;
      ACT_HLINE: begin
        ok          = on_grid && (x <= xe_c);
        col_last_in = xe_c[COORD_W-1:0];
      end
      ACT_VLINE: begin
        ok          = on_grid && (y <= ye_c);
        row_last_in = ye_c[COORD_W-1:0];
      end
      ACT_RECT: begin
        ok          = on_grid && (width != 8'd0) && (height != 8'd0);
        col_last_in = xr_m1[COORD_W-1:0];
        row_last_in = yb_m1[COORD_W-1:0];
      end
      default: ok = 1'b0;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      page <= 1'b0;
    end else if (cfg_wr_en) begin
      page <= cfg_wr_data;
    end
  end

  // Latched command and raster cursor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q    <= action;
      color_q  <= color;
      col      <= x[COORD_W-1:0];
      row      <= y[COORD_W-1:0];
      x_start  <= x[COORD_W-1:0];
      col_last <= col_last_in;
      row_last <= row_last_in;
    end else if (cmd.advance) begin
      if (col == col_last) begin
        col <= x_start;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Sweep counter for the reset pass and page clears
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_step) begin
      sweep <= sweep + 1'b1;
    end
  end

  // Cell address, nibble select and merge
  logic [ADDR_W-1:0] cur_addr;
  logic [3:0]        nib;
  logic [7:0]        merged;
  logic [3:0]        res_color;

  assign cur_addr  = cell_addr(page, col, row);
  assign nib       = row[0] ? rdata[7:4] : rdata[3:0];
  assign merged    = row[0] ? {color_q, rdata[3:0]} : {rdata[7:4], color_q};
  assign res_color = (cmd.cell_wr && (act_q == ACT_GET)) ? nib : pend_color;

  // Store write port select
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = merged;
    if (cmd.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = sweep;
      wr_data = '0;
    end else if (cmd.fill_wr) begin
      wr_en   = 1'b1;
      wr_addr = {page, sweep[PAGE_ADDR_W-1:0]};
      wr_data = {color_q, color_q};
    end else if (cmd.cell_wr && (act_q != ACT_GET)) begin
      wr_en = 1'b1;
    end
  end

  // Screen store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[cur_addr];
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pend_acc   <= ok;
      pend_color <= 4'd0;
    end else if (cmd.cell_wr) begin
      pend_color <= res_color;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_color <= res_color;
      out_acc   <= pend_acc;
    end
  end

  assign rsp_valid  = out_valid;
  assign read_color = out_color;
  assign accepted   = out_acc;

  // Status to controller
  always_comb begin
    stat.in_clear   = (action == ACT_CLEAR);
    stat.in_ok      = ok;
    stat.sweep_all  = &sweep;
    stat.sweep_page = &sweep[PAGE_ADDR_W-1:0];
    stat.cell_last  = (col == col_last) && (row == row_last);
    stat.out_free   = !out_valid || rsp_ready;
  end

endmodule

// File: src/lores_block_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// lores_block_framebuffer_unit
// Drawing engine over a 40 x 48 grid of 4-bit blocks held two to a byte in
// an interleaved two-page text memory. After reset a clearing pass zeroes
// the store and no command is taken until it ends. Each command yields one
// result. Lines and rectangles take a read and a write for every block
// drawn, since every block is a read-modify-write of its byte; clear writes
// one byte per cycle over the whole 1 KB page. A finished result sits in an
// output register, so the next command is taken while it waits.
// ----------------------------------------------------------------------------
module lores_block_framebuffer_unit
  import lbfb_pkg::*;
#(
  parameter int COLUMNS    = lbfb_pkg::COLUMNS,
  parameter int BLOCK_ROWS = lbfb_pkg::BLOCK_ROWS
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  lbfb_req_if.sink          req,
  lbfb_rsp_if.source        rsp
);

  lbfb_cmd_t  cmd;
  lbfb_stat_t stat;

  // Sequencer
  lbfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store and datapath
  lbfb_datapath #(
    .COLUMNS    (COLUMNS),
    .BLOCK_ROWS (BLOCK_ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .action      (req.action),
    .x           (req.x),
    .y           (req.y),
    .x_end       (req.x_end),
    .y_end       (req.y_end),
    .width       (req.width),
    .height      (req.height),
    .color       (req.color),
    .cmd         (cmd),
    .stat        (stat),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_color  (rsp.read_color),
    .accepted    (rsp.accepted)
  );

endmodule

// File: src/lbfb_checker.sv
// ----------------------------------------------------------------------------
// lbfb_checker
// Port-level checks on the framebuffer's command and result channels.
// ----------------------------------------------------------------------------
module lbfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [3:0] read_color,
  input logic       accepted
);

  // Result held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // A nonzero color only comes from a get that was carried out
  a_color_acc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (read_color != 4'd0) |-> accepted)
    else $error("color returned by a rejected command");

  // Clearing pass after reset blocks commands
  a_init_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("command taken during reset clearing pass");

  // One command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second command taken before the first finished");

endmodule

bind lores_block_framebuffer_unit lbfb_checker u_lbfb_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .read_color (rsp.read_color),
  .accepted   (rsp.accepted)
);

// File: test/lores_block_framebuffer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lores_block_framebuffer_unit_tb
// Self-checking bench for the block framebuffer. Drawing commands go in on
// the request channel and results come back on the response channel, with
// random idle cycles on both sides. A shadow copy of both screen pages
// predicts every result not typed in by hand. The bench runs a short table
// of directed commands and then random traffic, switching the display page
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module lores_block_framebuffer_unit_tb;
  import lbfb_pkg::*;

  // Action codes with no defined behavior; the block must ignore them
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int PAGE_BYTES   = 1024;
  localparam int RANDOM_ITEMS = 550;
  localparam int PHASES       = 4;
  // Slowest legal stretch without a transaction is a full-screen rectangle
  // or the reset clearing pass; keep a wide margin.
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 60;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [7:0] width;
    logic [7:0] height;
    logic [3:0] color;
  } draw_cmd_t;

  typedef struct packed {
    logic [3:0] read_color;
    logic       accepted;
  } draw_res_t;

  // One directed command; known marks a result typed in by hand
  typedef struct packed {
    draw_cmd_t cmd;
    logic      known;
    draw_res_t res;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  lbfb_req_if req ();
  lbfb_rsp_if rsp ();

  lores_block_framebuffer_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  // Shadow screen and display page
  logic [7:0] shadow_mem [0:STORE_DEPTH-1];
  logic       shadow_page;

  draw_res_t  pending_results [$];
  plan_row_t  directed_rows [$];

  int errors       = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int send_calm    = 0;
  int recv_calm    = 0;
  int recv_hold    = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Byte that holds block (x, y) on the current page
  function automatic int cell_byte(int x, int y);
    int r;
    r = y >> 1;
    return shadow_page * PAGE_BYTES + (r % 8) * 128 + 40 * (r / 8) + x;
  endfunction

  // Odd block rows live in the high nibble
  function automatic void paint_block(int x, int y, logic [3:0] color);
    int a;
    a = cell_byte(x, y);
    if (y % 2 == 1) begin
      shadow_mem[a][7:4] = color;
    end else begin
      shadow_mem[a][3:0] = color;
    end
  endfunction

  // Apply one command to the shadow screen and return its result
  function automatic draw_res_t draw_on_shadow(draw_cmd_t c);
    draw_res_t r;
    int        x, y, xe, ye, xr, yb, i, j, base;
    logic [7:0] b;
    logic       on_grid;
    r       = '0;
    x       = c.x;
    y       = c.y;
    on_grid = (x < COLUMNS) && (y < BLOCK_ROWS);
    case (c.action)
      ACT_CLEAR: begin
        // whole page, screen holes included
        base = shadow_page * PAGE_BYTES;
        for (i = 0; i < PAGE_BYTES; i++) shadow_mem[base + i] = {c.color, c.color};
        r.accepted = 1'b1;
      end
      ACT_SET: begin
        if (on_grid) begin
          paint_block(x, y, c.color);
          r.accepted = 1'b1;
        end
      end
      ACT_GET: begin
        if (on_grid) begin
          b            = shadow_mem[cell_byte(x, y)];
          r.read_color = (y % 2 == 1) ? b[7:4] : b[3:0];
          r.accepted   = 1'b1;
        end
      end
      ACT_HLINE: begin
        xe = (c.x_end >= COLUMNS) ? COLUMNS - 1 : c.x_end;
        if (on_grid && x <= xe) begin
          for (i = x; i <= xe; i++) paint_block(i, y, c.color);
          r.accepted = 1'b1;
        end
      end
      ACT_VLINE: begin
        ye = (c.y_end >= BLOCK_ROWS) ? BLOCK_ROWS - 1 : c.y_end;
        if (on_grid && y <= ye) begin
          for (j = y; j <= ye; j++) paint_block(x, j, c.color);
          r.accepted = 1'b1;
        end
      end
      ACT_RECT: begin
        if (on_grid && c.width != 0 && c.height != 0) begin
          xr = (x + c.width > COLUMNS) ? COLUMNS : x + c.width;
          yb = (y + c.height > BLOCK_ROWS) ? BLOCK_ROWS : y + c.height;
          for (j = y; j < yb; j++)
            for (i = x; i < xr; i++) paint_block(i, j, c.color);
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long, with calm stretches
  function automatic int gap_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int        pick, zone, r, lim;
    pick = $urandom_range(0, 99);
    zone = $urandom_range(0, 9);
    if (pick < 2)       c.action = ACT_CLEAR;
    else if (pick == 2) c.action = ACT_SPARE_6;
    else if (pick == 3) c.action = ACT_SPARE_7;
    else if (pick < 31) c.action = ACT_SET;
    else if (pick < 58) c.action = ACT_GET;
    else if (pick < 72) c.action = ACT_HLINE;
    else if (pick < 86) c.action = ACT_VLINE;
    else                c.action = ACT_RECT;
    // small corner window so reads often land on recent writes
    if (zone < 5) begin
      c.x = 8'($urandom_range(0, 7));
      c.y = 8'($urandom_range(0, 7));
    end else if (zone < 9) begin
      c.x = 8'($urandom_range(0, COLUMNS - 1));
      c.y = 8'($urandom_range(0, BLOCK_ROWS - 1));
    end else begin
      c.x = 8'($urandom_range(0, 255));
      c.y = 8'($urandom_range(0, 255));
    end
    c.x_end  = 8'($urandom_range(0, 255));
    c.y_end  = 8'($urandom_range(0, 255));
    c.width  = 8'($urandom_range(0, 255));
    c.height = 8'($urandom_range(0, 255));
    c.color  = 4'($urandom_range(0, 15));
    case (c.action)
      ACT_HLINE: if ($urandom_range(0, 4) != 0) c.x_end = 8'(c.x + $urandom_range(0, 10));
      ACT_VLINE: if ($urandom_range(0, 4) != 0) c.y_end = 8'(c.y + $urandom_range(0, 10));
      ACT_RECT: begin
        // keep most rectangles small; a full-screen fill is slow
        r        = $urandom_range(0, 99);
        lim      = (r < 85) ? 6 : (r < 98) ? 20 : 255;
        c.width  = 8'($urandom_range(0, lim));
        c.height = 8'($urandom_range(0, lim));
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic add_row(logic [2:0] action, int x, int y, int xe, int ye, int w, int h,
                         int color, logic known, int rd, logic acc);
    plan_row_t row;
    row.cmd.action     = action;
    row.cmd.x          = 8'(x);
    row.cmd.y          = 8'(y);
    row.cmd.x_end      = 8'(xe);
    row.cmd.y_end      = 8'(ye);
    row.cmd.width      = 8'(w);
    row.cmd.height     = 8'(h);
    row.cmd.color      = 4'(color);
    row.known          = known;
    row.res.read_color = 4'(rd);
    row.res.accepted   = acc;
    directed_rows.push_back(row);
  endtask

  // Predict, then hold the command on the bus until the block takes it
  task automatic issue(draw_cmd_t c, logic known, draw_res_t typed);
    draw_res_t predicted;
    int        gap;
    predicted = draw_on_shadow(c);
    pending_results.push_back(known ? typed : predicted);
    gap = gap_len(send_calm);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.action <= c.action;
    req.x      <= c.x;
    req.y      <= c.y;
    req.x_end  <= c.x_end;
    req.y_end  <= c.y_end;
    req.width  <= c.width;
    req.height <= c.height;
    req.color  <= c.color;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Page switch only once every result is back
  task automatic write_page(logic page);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= page;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_page  = page;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: result %0d %s: got %0d, want %0d", $time, results_seen, what, got, want);
  endtask

  // Result side: random back-pressure
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      rsp.ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      rsp.ready <= 1'b1;
      recv_hold <= gap_len(recv_calm);
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    draw_res_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.read_color, rsp.accepted};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command pending", int'(got), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.read_color !== want.read_color)
          report_mismatch("read_color", int'(got.read_color), int'(want.read_color));
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", int'(got.accepted), int'(want.accepted));
      end
      results_seen++;
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("lores_block_framebuffer_unit_tb NOT OK");
    $finish;
  end

  // Stimulus
  initial begin
    int k, ph, n;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    req.valid   = 1'b0;
    req.action  = ACT_CLEAR;
    req.x       = '0;
    req.y       = '0;
    req.x_end   = '0;
    req.y_end   = '0;
    req.width   = '0;
    req.height  = '0;
    req.color   = '0;
    rsp.ready   = 1'b0;
    shadow_page = 1'b0;
    for (k = 0; k < STORE_DEPTH; k++) shadow_mem[k] = '0;

    //      action       x    y    xe   ye   w    h    col known rd acc
    add_row(ACT_GET,     0,   0,   0,   0,   0,   0,   0,  1,   0, 1);  // fresh store
    add_row(ACT_GET,     39,  47,  0,   0,   0,   0,   0,  1,   0, 1);
    add_row(ACT_SET,     0,   0,   0,   0,   0,   0,   15, 1,   0, 1);
    add_row(ACT_SET,     0,   1,   0,   0,   0,   0,   5,  1,   0, 1);  // same byte, high
    add_row(ACT_GET,     0,   0,   0,   0,   0,   0,   0,  1,   15, 1);
    add_row(ACT_GET,     0,   1,   0,   0,   0,   0,   0,  1,   5, 1);
    add_row(ACT_SET,     39,  47,  0,   0,   0,   0,   10, 1,   0, 1);
    add_row(ACT_GET,     39,  47,  0,   0,   0,   0,   0,  1,   10, 1);
    add_row(ACT_SET,     40,  0,   0,   0,   0,   0,   3,  1,   0, 0);  // column off grid
    add_row(ACT_GET,     0,   48,  0,   0,   0,   0,   0,  1,   0, 0);  // row off grid
    add_row(ACT_SET,     255, 255, 255, 255, 255, 255, 15, 1,   0, 0);
    add_row(ACT_HLINE,   2,   3,   255, 0,   0,   0,   7,  1,   0, 1);  // end clamped
    add_row(ACT_HLINE,   10,  4,   5,   0,   0,   0,   7,  1,   0, 0);  // reversed
    add_row(ACT_HLINE,   40,  4,   255, 0,   0,   0,   7,  1,   0, 0);
    add_row(ACT_VLINE,   5,   0,   0,   255, 0,   0,   3,  1,   0, 1);  // end clamped
    add_row(ACT_VLINE,   6,   20,  0,   10,  0,   0,   3,  1,   0, 0);  // reversed
    add_row(ACT_VLINE,   6,   48,  0,   255, 0,   0,   3,  1,   0, 0);
    add_row(ACT_RECT,    30,  40,  0,   0,   255, 255, 9,  1,   0, 1);  // overhang
    add_row(ACT_RECT,    1,   1,   0,   0,   0,   5,   9,  1,   0, 0);  // zero width
    add_row(ACT_RECT,    1,   1,   0,   0,   5,   0,   9,  1,   0, 0);  // zero height
    add_row(ACT_SPARE_6, 3,   3,   9,   9,   4,   4,   4,  1,   0, 0);
    add_row(ACT_SPARE_7, 3,   3,   9,   9,   4,   4,   4,  1,   0, 0);
    add_row(ACT_GET,     39,  47,  0,   0,   0,   0,   0,  0,   0, 0);
    add_row(ACT_GET,     5,   21,  0,   0,   0,   0,   0,  0,   0, 0);
    add_row(ACT_GET,     20,  3,   0,   0,   0,   0,   0,  0,   0, 0);
    add_row(ACT_CLEAR,   0,   0,   0,   0,   0,   0,   12, 1,   0, 1);
    add_row(ACT_GET,     17,  33,  0,   0,   0,   0,   0,  1,   12, 1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_page(1'b0);
    foreach (directed_rows[k])
      issue(directed_rows[k].cmd, directed_rows[k].known, directed_rows[k].res);

    // random traffic, alternating pages
    for (ph = 0; ph < PHASES; ph++) begin
      write_page(ph % 2 == 0);
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) issue(rand_cmd(), 1'b0, '0);
    end

    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("lores_block_framebuffer_unit_tb OK");
    end else begin
      $display("lores_block_framebuffer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
